@@ rtl/rsz_pkg.sv @@
// ----------------------------------------------------------------------------
// rsz_pkg: shared types and constants for the bilinear resize core
// Store geometry, fixed-point widths, register indexes and item formats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsz_pkg;

  localparam int unsigned MAX_WIDTH    = 256;
  localparam int unsigned MAX_HEIGHT   = 256;
  localparam int unsigned MAX_CHANNELS = 3;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned FRAC_W  = 16;

  // size * (2*index+1) fits in 17 bits; numerator is that shifted by FRAC_W
  localparam int unsigned PROD_W     = 17;
  localparam int unsigned NUM_W      = PROD_W + FRAC_W;
  localparam int unsigned DIV_W      = SIZE_W + 1;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_STEPS;

  // four banks split by column and row parity
  localparam int unsigned BANK_AW    = CH_W + 2 * (COORD_W - 1);
  localparam int unsigned BANK_DEPTH = MAX_CHANNELS * (MAX_HEIGHT / 2) * (MAX_WIDTH / 2);

  localparam int unsigned REG_AW = 3;
  localparam logic [REG_AW-1:0] REG_SRC_W    = 3'd0;
  localparam logic [REG_AW-1:0] REG_SRC_H    = 3'd1;
  localparam logic [REG_AW-1:0] REG_DST_W    = 3'd2;
  localparam logic [REG_AW-1:0] REG_DST_H    = 3'd3;
  localparam logic [REG_AW-1:0] REG_CHAN_CNT = 3'd4;
  localparam logic [REG_AW-1:0] REG_MODE     = 3'd5;

  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_REQUEST  = 1'b1;
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [SIZE_W-1:0] dst_w;
    logic [SIZE_W-1:0] dst_h;
    logic [CH_W-1:0]   chan_cnt;
    logic              mode;
  } cfg_t;

  typedef struct packed {
    logic               is_req;
    logic               wr_ok;
    logic [CH_W-1:0]    chan;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SMP_W-1:0]   sample;
    logic [NUM_W-1:0]   nx;
    logic [NUM_W-1:0]   ny;
  } cmd_t;

  // zero acts as one, anything above the limit saturates
  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v,
                                                 logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

@@ rtl/rsz_ram.sv @@
// ----------------------------------------------------------------------------
// rsz_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered under read enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsz_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rsz_front.sv @@
// ----------------------------------------------------------------------------
// rsz_front: input side of the resize core
// Accepts words, decodes write vs request, forms the coordinate numerators
// and holds them in a four-entry queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsz_front import rsz_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic               func_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [CH_W-1:0]    channel_i,
  input  logic [SMP_W-1:0]   sample_i,
  output cmd_t               cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  cmd_t              q_mem_q [QDEPTH];
  logic [QAW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QAW:0]      cnt_q, cnt_d;
  logic              acc_push, acc_pop;
  cmd_t              cmd;

  logic [SIZE_W-1:0] sw, sh, dw, dh;
  logic [CH_W-1:0]   nc;
  logic [2*SIZE_W-1:0] prod_x, prod_y;

  always_comb begin
    sw = eff_size(cfg_i.src_w, SIZE_W'(MAX_WIDTH));
    sh = eff_size(cfg_i.src_h, SIZE_W'(MAX_HEIGHT));
    dw = eff_size(cfg_i.dst_w, '1);
    dh = eff_size(cfg_i.dst_h, '1);
    if (cfg_i.chan_cnt == '0) nc = CH_W'(1);
    else if (cfg_i.chan_cnt > CH_W'(MAX_CHANNELS)) nc = CH_W'(MAX_CHANNELS);
    else nc = cfg_i.chan_cnt;

    prod_x = (2*SIZE_W)'(sw) * (2*SIZE_W)'({col_i, 1'b1});
    prod_y = (2*SIZE_W)'(sh) * (2*SIZE_W)'({row_i, 1'b1});

    cmd.is_req = (func_i == FUNC_REQUEST);
    cmd.wr_ok  = (32'(channel_i) < MAX_CHANNELS);
    cmd.col    = col_i;
    cmd.row    = row_i;
    cmd.sample = sample_i;
    if (func_i == FUNC_REQUEST && channel_i >= nc) cmd.chan = nc - CH_W'(1);
    else cmd.chan = channel_i;
    // numerator = size*(2i+1)*2^16 + dst, the add never carries into the product
    cmd.nx = {prod_x[PROD_W-1:0], (FRAC_W - SIZE_W)'(0), dw};
    cmd.ny = {prod_y[PROD_W-1:0], (FRAC_W - SIZE_W)'(0), dh};
  end

  assign full_o      = (cnt_q == (QAW+1)'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rptr_q];
  assign acc_push    = push_i & ~full_o;
  assign acc_pop     = cmd_pop_i & cmd_valid_o;

  always_comb begin
    wptr_d = acc_push ? wptr_q + QAW'(1) : wptr_q;
    rptr_d = acc_pop ? rptr_q + QAW'(1) : rptr_q;
    cnt_d  = cnt_q + (QAW+1)'(acc_push) - (QAW+1)'(acc_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_push) begin
      q_mem_q[wptr_q] <= cmd;
    end
  end

endmodule

@@ rtl/rsz_back.sv @@
// ----------------------------------------------------------------------------
// rsz_back: execution side of the resize core
// Pipelined divide for the source coordinates, clamp, four-bank store
// access, area weighting and rounding, then a two-entry result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsz_back import rsz_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  cmd_t             cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [SMP_W-1:0] pixel_value_o,
  output logic             is_answer_o
);

  localparam int unsigned  W_W   = 2*FRAC_W + 1;
  localparam int unsigned  P_W   = W_W + SMP_W;
  localparam int unsigned  XB_W  = 20;
  localparam int unsigned  ODEPTH = 2;
  // Q16 offset: +16.0 to keep positive, -0.5 from the mapping
  localparam logic [NUM_W:0] BIAS = (NUM_W+1)'(16*65536 - 32768);

  typedef struct packed {
    logic             v;
    cmd_t             c;
    logic [DIV_W-1:0] rx;
    logic [DIV_W-1:0] ry;
  } div_t;

  typedef struct packed {
    logic                   v;
    logic                   is_req;
    logic                   wr_ok;
    logic [CH_W-1:0]        chan;
    logic [COORD_W-1:0]     col;
    logic [COORD_W-1:0]     row;
    logic [SMP_W-1:0]       sample;
    logic signed [XB_W-1:0] xb;
    logic signed [XB_W-1:0] yb;
    logic [FRAC_W-1:0]      fx;
    logic [FRAC_W-1:0]      fy;
  } sa_t;

  typedef struct packed {
    logic               v;
    logic               is_req;
    logic               wr_ok;
    logic [CH_W-1:0]    chan;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SMP_W-1:0]   sample;
    logic [COORD_W-1:0] cx0;
    logic [COORD_W-1:0] cx1;
    logic [COORD_W-1:0] cy0;
    logic [COORD_W-1:0] cy1;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
  } sb_t;

  typedef struct packed {
    logic           v;
    logic           is_req;
    logic [W_W-1:0] w00;
    logic [W_W-1:0] w10;
    logic [W_W-1:0] w01;
    logic [W_W-1:0] w11;
    logic           x0;
    logic           x1;
    logic           y0;
    logic           y1;
  } sc_t;

  typedef struct packed {
    logic           v;
    logic           is_req;
    logic [P_W-1:0] p0;
    logic [P_W-1:0] p1;
    logic [P_W-1:0] p2;
    logic [P_W-1:0] p3;
  } sd_t;

  typedef struct packed {
    logic           v;
    logic           is_req;
    logic [P_W-1:0] s01;
    logic [P_W-1:0] s23;
  } se_t;

  function automatic logic [NUM_W+DIV_W-1:0] div_step(logic [NUM_W-1:0] n,
                                                      logic [DIV_W-1:0] r,
                                                      logic [DIV_W-1:0] d);
    logic [DIV_W:0] s;
    logic           qb;
    s  = {r, n[NUM_W-1]};
    qb = 1'b0;
    if (s >= {1'b0, d}) begin
      s  = s - {1'b0, d};
      qb = 1'b1;
    end
    return {n[NUM_W-2:0], qb, s[DIV_W-1:0]};
  endfunction

  function automatic logic [COORD_W-1:0] clamp_c(logic signed [XB_W-1:0] v,
                                                 logic [SIZE_W-1:0] sz);
    logic signed [XB_W-1:0] hi;
    logic [COORD_W-1:0]     r;
    hi = $signed({(XB_W-SIZE_W)'(0), sz}) - XB_W'(1);
    if (v < 0) r = '0;
    else if (v > hi) r = hi[COORD_W-1:0];
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  logic              en;
  logic [SIZE_W-1:0] sw, sh, dw, dh;
  logic [DIV_W-1:0]  dx, dy;

  div_t div_q [DIV_STAGES+1];
  div_t div_d [DIV_STAGES+1];
  sa_t  sa_q, sa_d;
  sb_t  sb_q, sb_d;
  sc_t  sc_q, sc_d;
  sd_t  sd_q, sd_d;
  se_t  se_q, se_d;

  logic [SMP_W-1:0]   rdata [4];
  logic [BANK_AW-1:0] raddr [4];
  logic               bank_we [4];
  logic [BANK_AW-1:0] waddr;
  logic               re;

  logic [SMP_W:0]     out_word;
  logic [SMP_W:0]     ofifo_q [ODEPTH];
  logic [$clog2(ODEPTH)-1:0] owp_q, orp_q;
  logic [$clog2(ODEPTH):0]   ocnt_q, ocnt_d;
  logic               opush, opop;

  assign sw = eff_size(cfg_i.src_w, SIZE_W'(MAX_WIDTH));
  assign sh = eff_size(cfg_i.src_h, SIZE_W'(MAX_HEIGHT));
  assign dw = eff_size(cfg_i.dst_w, '1);
  assign dh = eff_size(cfg_i.dst_h, '1);
  assign dx = {dw, 1'b0};
  assign dy = {dh, 1'b0};

  // whole pipe advances together whenever the result buffer has room
  assign en        = (ocnt_q != ($clog2(ODEPTH)+1)'(ODEPTH));
  assign cmd_pop_o = en & cmd_valid_i;

  // divider: three quotient bits per stage
  always_comb begin
    div_d[0].v  = cmd_valid_i;
    div_d[0].c  = cmd_i;
    div_d[0].rx = '0;
    div_d[0].ry = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      div_d[k] = div_q[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        {div_d[k].c.nx, div_d[k].rx} = div_step(div_d[k].c.nx, div_d[k].rx, dx);
        {div_d[k].c.ny, div_d[k].ry} = div_step(div_d[k].c.ny, div_d[k].ry, dy);
      end
    end
  end

  // quotients now hold the Q16 source position plus one half
  always_comb begin
    logic [NUM_W:0] tx, ty;
    div_t           dq;
    dq = div_q[DIV_STAGES];
    tx = {1'b0, dq.c.nx} + BIAS;
    ty = {1'b0, dq.c.ny} + BIAS;
    sa_d.v      = dq.v;
    sa_d.is_req = dq.c.is_req;
    sa_d.wr_ok  = dq.c.wr_ok;
    sa_d.chan   = dq.c.chan;
    sa_d.col    = dq.c.col;
    sa_d.row    = dq.c.row;
    sa_d.sample = dq.c.sample;
    if (cfg_i.mode == MODE_BILINEAR) begin
      sa_d.xb = $signed({2'b0, tx[NUM_W:FRAC_W]}) - XB_W'(16);
      sa_d.yb = $signed({2'b0, ty[NUM_W:FRAC_W]}) - XB_W'(16);
      sa_d.fx = tx[FRAC_W-1:0];
      sa_d.fy = ty[FRAC_W-1:0];
    end else begin
      // round half up; negative positions clamp to zero anyway
      sa_d.xb = $signed({3'b0, dq.c.nx[NUM_W-1:FRAC_W]});
      sa_d.yb = $signed({3'b0, dq.c.ny[NUM_W-1:FRAC_W]});
      sa_d.fx = '0;
      sa_d.fy = '0;
    end
  end

  always_comb begin
    sb_d.v      = sa_q.v;
    sb_d.is_req = sa_q.is_req;
    sb_d.wr_ok  = sa_q.wr_ok;
    sb_d.chan   = sa_q.chan;
    sb_d.col    = sa_q.col;
    sb_d.row    = sa_q.row;
    sb_d.sample = sa_q.sample;
    sb_d.cx0    = clamp_c(sa_q.xb, sw);
    sb_d.cx1    = clamp_c(sa_q.xb + XB_W'(1), sw);
    sb_d.cy0    = clamp_c(sa_q.yb, sh);
    sb_d.cy1    = clamp_c(sa_q.yb + XB_W'(1), sh);
    sb_d.fx     = sa_q.fx;
    sb_d.fy     = sa_q.fy;
  end

  // bank b holds column parity b[0], row parity b[1]
  always_comb begin
    logic               px, py;
    logic [COORD_W-1:0] xs, ys;
    waddr = {sb_q.chan, sb_q.row[COORD_W-1:1], sb_q.col[COORD_W-1:1]};
    re    = en & sb_q.v & sb_q.is_req;
    for (int b = 0; b < 4; b++) begin
      px = 1'(b % 2);
      py = 1'(b / 2);
      xs = (sb_q.cx0[0] == px) ? sb_q.cx0 : sb_q.cx1;
      ys = (sb_q.cy0[0] == py) ? sb_q.cy0 : sb_q.cy1;
      raddr[b]   = {sb_q.chan, ys[COORD_W-1:1], xs[COORD_W-1:1]};
      bank_we[b] = en & sb_q.v & ~sb_q.is_req & sb_q.wr_ok &
                   (sb_q.col[0] == px) & (sb_q.row[0] == py);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    rsz_ram #(
      .WIDTH (SMP_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (waddr),
      .wdata_i (sb_q.sample),
      .re_i    (re),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  always_comb begin
    logic [FRAC_W:0]   gx, gy;
    logic [2*W_W-1:0]  m00, m10, m01, m11;
    gx  = (FRAC_W+1)'(65536) - {1'b0, sb_q.fx};
    gy  = (FRAC_W+1)'(65536) - {1'b0, sb_q.fy};
    m00 = (2*W_W)'(gx) * (2*W_W)'(gy);
    m10 = (2*W_W)'(sb_q.fx) * (2*W_W)'(gy);
    m01 = (2*W_W)'(gx) * (2*W_W)'(sb_q.fy);
    m11 = (2*W_W)'(sb_q.fx) * (2*W_W)'(sb_q.fy);
    sc_d.v      = sb_q.v;
    sc_d.is_req = sb_q.is_req;
    sc_d.w00    = m00[W_W-1:0];
    sc_d.w10    = m10[W_W-1:0];
    sc_d.w01    = m01[W_W-1:0];
    sc_d.w11    = m11[W_W-1:0];
    sc_d.x0     = sb_q.cx0[0];
    sc_d.x1     = sb_q.cx1[0];
    sc_d.y0     = sb_q.cy0[0];
    sc_d.y1     = sb_q.cy1[0];
  end

  always_comb begin
    sd_d.v      = sc_q.v;
    sd_d.is_req = sc_q.is_req;
    sd_d.p0     = P_W'(sc_q.w00) * P_W'(rdata[{sc_q.y0, sc_q.x0}]);
    sd_d.p1     = P_W'(sc_q.w10) * P_W'(rdata[{sc_q.y0, sc_q.x1}]);
    sd_d.p2     = P_W'(sc_q.w01) * P_W'(rdata[{sc_q.y1, sc_q.x0}]);
    sd_d.p3     = P_W'(sc_q.w11) * P_W'(rdata[{sc_q.y1, sc_q.x1}]);
  end

  always_comb begin
    se_d.v      = sd_q.v;
    se_d.is_req = sd_q.is_req;
    se_d.s01    = sd_q.p0 + sd_q.p1;
    se_d.s23    = sd_q.p2 + sd_q.p3;
  end

  // round half up from Q32, saturate to 16 bits
  always_comb begin
    logic [P_W-1:0]          tot;
    logic [P_W-2*FRAC_W-1:0] rnd;
    logic [SMP_W-1:0]        val;
    tot = se_q.s01 + se_q.s23 + P_W'(64'd1 << (2*FRAC_W - 1));
    rnd = tot[P_W-1:2*FRAC_W];
    if (rnd > (P_W-2*FRAC_W)'(16'hFFFF)) val = '1;
    else val = rnd[SMP_W-1:0];
    out_word = se_q.is_req ? {1'b1, val} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        div_q[k].v <= 1'b0;
      end
      sa_q.v <= 1'b0;
      sb_q.v <= 1'b0;
      sc_q.v <= 1'b0;
      sd_q.v <= 1'b0;
      se_q.v <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        div_q[k] <= div_d[k];
      end
      sa_q <= sa_d;
      sb_q <= sb_d;
      sc_q <= sc_d;
      sd_q <= sd_d;
      se_q <= se_d;
    end
  end

  // result buffer
  assign opush         = en & se_q.v;
  assign empty_o       = (ocnt_q == '0);
  assign opop          = pop_i & ~empty_o;
  assign pixel_value_o = ofifo_q[orp_q][SMP_W-1:0];
  assign is_answer_o   = ofifo_q[orp_q][SMP_W];
  assign ocnt_d        = ocnt_q + ($clog2(ODEPTH)+1)'(opush)
                                - ($clog2(ODEPTH)+1)'(opop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (opush) owp_q <= owp_q + 1'b1;
      if (opop) orp_q <= orp_q + 1'b1;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      ofifo_q[owp_q] <= out_word;
    end
  end

endmodule

@@ rtl/bilinear_image_resize_core.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_resize_core: image scaler with bilinear / nearest sampling
// Throughput: one word per cycle while the result buffer has room; the store
// is four parity banks so all four neighbors are read in the same cycle.
// Reset: configuration returns to 256x256 -> 256x256, 3 channels, bilinear;
// queues empty. The image store is not cleared and holds nothing until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_image_resize_core import rsz_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [REG_AW-1:0]  cfg_addr_i,
  input  logic [SIZE_W-1:0]  cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic               func_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [CH_W-1:0]    channel_i,
  input  logic [SMP_W-1:0]   sample_i,
  output logic               empty,
  input  logic               pop,
  output logic [SMP_W-1:0]   pixel_value_o,
  output logic               is_answer_o
);

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SRC_W:    cfg_d.src_w    = cfg_wdata_i;
        REG_SRC_H:    cfg_d.src_h    = cfg_wdata_i;
        REG_DST_W:    cfg_d.dst_w    = cfg_wdata_i;
        REG_DST_H:    cfg_d.dst_h    = cfg_wdata_i;
        REG_CHAN_CNT: cfg_d.chan_cnt = cfg_wdata_i[CH_W-1:0];
        REG_MODE:     cfg_d.mode     = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w    <= SIZE_W'(MAX_WIDTH);
      cfg_q.src_h    <= SIZE_W'(MAX_HEIGHT);
      cfg_q.dst_w    <= SIZE_W'(256);
      cfg_q.dst_h    <= SIZE_W'(256);
      cfg_q.chan_cnt <= CH_W'(MAX_CHANNELS);
      cfg_q.mode     <= MODE_BILINEAR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rsz_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  rsz_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .pixel_value_o (pixel_value_o),
    .is_answer_o   (is_answer_o)
  );

endmodule

@@ test/bilinear_image_resize_core_test.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_resize_core_test: self-checking bench for the resize core
// Each phase programs the registers while the core is idle and fills the
// whole source region. It then sends requests with random coordinates and
// stray writes. A scoreboard predicts every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_image_resize_core_test;
  import rsz_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned STORE_WORDS = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;

  typedef struct {
    logic               func;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CH_W-1:0]    chan;
    logic [SMP_W-1:0]   sample;
  } item_t;

  typedef struct {
    logic [SMP_W-1:0] pixel;
    logic             answer;
  } word_t;

  class resize_scoreboard;
    logic [SMP_W-1:0]  img [STORE_WORDS];
    logic [SIZE_W-1:0] src_w = 256, src_h = 256, dst_w = 256, dst_h = 256;
    logic [CH_W-1:0]   chan_cnt = 3;
    logic              mode = MODE_BILINEAR;
    word_t             pending_q [$];
    int                errors = 0;

    function void set_reg(logic [REG_AW-1:0] idx, logic [SIZE_W-1:0] v);
      case (idx)
        REG_SRC_W:    src_w = v;
        REG_SRC_H:    src_h = v;
        REG_DST_W:    dst_w = v;
        REG_DST_H:    dst_h = v;
        REG_CHAN_CNT: chan_cnt = v[CH_W-1:0];
        REG_MODE:     mode = v[0];
        default: ;
      endcase
    endfunction

    function longint limit_size(longint v, longint maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function longint src_pos(longint src, longint dst, longint i);
      return (src * (2 * i + 1) * 65536 + dst) / (2 * dst) - 32768;
    endfunction

    function longint round_pos(longint v);
      if (v >= 0) return (v + 32768) >>> 16;
      return -((-v + 32768) >>> 16);
    endfunction

    function longint texel(longint x, longint y, longint c, longint sw, longint sh);
      longint cx, cy;
      cx = (x < 0) ? 0 : (x > sw - 1) ? sw - 1 : x;
      cy = (y < 0) ? 0 : (y > sh - 1) ? sh - 1 : y;
      return longint'(img[(c * MAX_HEIGHT + cy) * MAX_WIDTH + cx]);
    endfunction

    function logic [SMP_W-1:0] resample(item_t it);
      longint sw, sh, dw, dh, nc, c, xq, yq, tx, ty, xl, yl, fx, fy, gx, gy, r;
      longint unsigned acc;
      sw = limit_size(src_w, MAX_WIDTH);
      sh = limit_size(src_h, MAX_HEIGHT);
      dw = limit_size(dst_w, 511);
      dh = limit_size(dst_h, 511);
      nc = limit_size(chan_cnt, MAX_CHANNELS);
      c  = (it.chan < nc) ? it.chan : nc - 1;
      xq = src_pos(sw, dw, it.col);
      yq = src_pos(sh, dh, it.row);
      if (mode == MODE_NEAREST) return SMP_W'(texel(round_pos(xq), round_pos(yq), c, sw, sh));
      tx = xq + (64'sd16 <<< 16);
      ty = yq + (64'sd16 <<< 16);
      xl = (tx >>> 16) - 16;
      yl = (ty >>> 16) - 16;
      fx = tx & 'hFFFF;
      fy = ty & 'hFFFF;
      gx = 65536 - fx;
      gy = 65536 - fy;
      acc = gx * gy * texel(xl, yl, c, sw, sh) + fx * gy * texel(xl + 1, yl, c, sw, sh)
          + gx * fy * texel(xl, yl + 1, c, sw, sh) + fx * fy * texel(xl + 1, yl + 1, c, sw, sh);
      r = longint'((acc + 64'd2147483648) >> 32);
      if (r > 'hFFFF) r = 'hFFFF;
      return SMP_W'(r);
    endfunction

    function void note_input(item_t it);
      word_t w;
      if (it.func == FUNC_WRITE) begin
        if (it.chan < MAX_CHANNELS)
          img[(int'(it.chan) * MAX_HEIGHT + it.row) * MAX_WIDTH + it.col] = it.sample;
        w.pixel = '0;
        w.answer = 1'b0;
      end else begin
        w.pixel = resample(it);
        w.answer = 1'b1;
      end
      pending_q.push_back(w);
    endfunction

    function void check_word(logic [SMP_W-1:0] pix, logic ans);
      word_t w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word pixel=%h answer=%b", $time, pix, ans);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (pix !== w.pixel) begin
        $display("%0t: pixel_value expected %h actual %h", $time, w.pixel, pix);
        errors++;
      end
      if (ans !== w.answer) begin
        $display("%0t: is_answer expected %b actual %b", $time, w.answer, ans);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [REG_AW-1:0]  cfg_addr_i = '0;
  logic [SIZE_W-1:0]  cfg_wdata_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic               func_i = 1'b0;
  logic [COORD_W-1:0] col_i = '0;
  logic [COORD_W-1:0] row_i = '0;
  logic [CH_W-1:0]    channel_i = '0;
  logic [SMP_W-1:0]   sample_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [SMP_W-1:0]   pixel_value_o;
  logic               is_answer_o;

  resize_scoreboard sb = new();
  int unsigned      cycles = 0;
  int               burst_left = 0;
  int               items_sent = 0;

  bilinear_image_resize_core dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: stall pattern switches between free running, light and heavy
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (pop && !empty) sb.check_word(pixel_value_o, is_answer_o);
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      default: pop <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic wait_idle();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_AW-1:0] idx, logic [SIZE_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic send_word(item_t it);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    push <= 1'b1;
    func_i <= it.func;
    col_i <= it.col;
    row_i <= it.row;
    channel_i <= it.chan;
    sample_i <= it.sample;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    sb.note_input(it);
    burst_left--;
    items_sent++;
  endtask

  task automatic run_phase(logic [SIZE_W-1:0] sw, logic [SIZE_W-1:0] sh,
                           logic [SIZE_W-1:0] dw, logic [SIZE_W-1:0] dh,
                           logic [CH_W-1:0] nc, logic md, int n_req);
    item_t it;
    int ew, eh, en;
    push <= 1'b0;
    burst_left = 0;
    wait_idle();
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_DST_W, dw);
    write_reg(REG_DST_H, dh);
    write_reg(REG_CHAN_CNT, nc);
    write_reg(REG_MODE, SIZE_W'(md));
    cfg_we_i <= 1'b0;
    ew = (sw == 0) ? 1 : (sw > MAX_WIDTH) ? MAX_WIDTH : sw;
    eh = (sh == 0) ? 1 : (sh > MAX_HEIGHT) ? MAX_HEIGHT : sh;
    en = (nc == 0) ? 1 : nc;
    // fill every sample a request can reach
    for (int c = 0; c < en; c++)
      for (int y = 0; y < eh; y++)
        for (int x = 0; x < ew; x++) begin
          it.func = FUNC_WRITE;
          it.col = COORD_W'(x);
          it.row = COORD_W'(y);
          it.chan = CH_W'(c);
          case ($urandom_range(0, 7))
            0: it.sample = '0;
            1: it.sample = '1;
            default: it.sample = SMP_W'($urandom_range(0, 65535));
          endcase
          send_word(it);
        end
    for (int k = 0; k < n_req; k++) begin
      it.func = ($urandom_range(0, 9) == 0) ? FUNC_WRITE : FUNC_REQUEST;
      it.sample = SMP_W'($urandom_range(0, 65535));
      it.chan = CH_W'($urandom_range(0, 3));
      if (it.func == FUNC_WRITE && it.chan != 3) begin
        // stray write inside the filled region keeps every read defined
        it.col = COORD_W'($urandom_range(0, ew - 1));
        it.row = COORD_W'($urandom_range(0, eh - 1));
        if (it.chan >= en) it.chan = 3;
      end else begin
        it.col = ($urandom_range(0, 7) == 0) ? 8'hFF : COORD_W'($urandom_range(0, 255));
        it.row = ($urandom_range(0, 7) == 0) ? 8'hFF : COORD_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
          it.col = COORD_W'($urandom_range(0, (dw > 255 || dw == 0) ? 255 : dw - 1));
          it.row = COORD_W'($urandom_range(0, (dh > 255 || dh == 0) ? 255 : dh - 1));
        end
      end
      send_word(it);
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] rw, rh;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // extremes: widest and tallest strips, oversize source, zero registers
    run_phase(256, 1, 1, 511, 1, MODE_BILINEAR, 12);
    run_phase(511, 1, 255, 3, 1, MODE_NEAREST, 12);
    run_phase(1, 256, 7, 256, 1, MODE_NEAREST, 12);
    run_phase(0, 0, 0, 0, 0, MODE_BILINEAR, 8);
    run_phase(2, 2, 256, 256, 2, MODE_BILINEAR, 12);
    while (items_sent < 880) begin
      rw = SIZE_W'($urandom_range(0, 8));
      rh = SIZE_W'($urandom_range(0, 8));
      run_phase(rw, rh,
                SIZE_W'($urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(1, 16)),
                SIZE_W'($urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(1, 16)),
                CH_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 40);
    end
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rsz_pkg.sv
rtl/rsz_ram.sv
rtl/rsz_front.sv
rtl/rsz_back.sv
rtl/bilinear_image_resize_core.sv
test/bilinear_image_resize_core_test.sv
